// ===== sv/lr_pkg.sv =====
// Shared constants and control types for the line rasterizer.
package lr_pkg;

	localparam int COORD_W   = 6;
	localparam int ERR_W     = COORD_W + 3;
	localparam int TILE_SIZE_DEF = 64;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct packed {
		logic load;
		logic step;
	} lr_cmd_t;

	typedef struct packed {
		logic last;
	} lr_status_t;

endpackage

// ===== sv/lr_ctrl.sv =====
// Control state machine: segment intake and pixel handshake sequencing.
module lr_ctrl
	import lr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  lr_status_t status,
	output lr_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic state_q;
	logic state_d;
	logic out_xfer;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign out_xfer  = out_valid && !out_stall;

	assign cmd.load = in_valid && !in_stall;
	assign cmd.step = out_xfer && !status.last;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// leave once the final pixel transaction completes
				if (out_xfer && status.last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/lr_datapath.sv =====
// Datapath: endpoint setup, Bresenham error term and pixel coordinate registers.
module lr_datapath
	import lr_pkg::*;
#(
	parameter int TILE_SIZE = TILE_SIZE_DEF
) (
	input  logic       clk,
	input  lr_cmd_t    cmd,
	input  coord_t     x_begin,
	input  coord_t     y_begin,
	input  coord_t     x_finish,
	input  coord_t     y_finish,
	output lr_status_t status,
	output coord_t     pixel_x,
	output coord_t     pixel_y,
	output logic       last_pixel
);

	localparam coord_t MAX_C = COORD_W'(TILE_SIZE - 1);

	coord_t x0, y0, x1, y1;
	coord_t dx, dy, dmaj, dmin;
	coord_t maj0, maj1, min0, min1;
	logic   steep, swap;

	coord_t major_q, minor_q, major_end_q;
	logic   steep_q, minor_up_q;
	err_t   err_q, inc_a_q, inc_b_q;

	assign x0 = (x_begin  > MAX_C) ? MAX_C : x_begin;
	assign y0 = (y_begin  > MAX_C) ? MAX_C : y_begin;
	assign x1 = (x_finish > MAX_C) ? MAX_C : x_finish;
	assign y1 = (y_finish > MAX_C) ? MAX_C : y_finish;

	assign dx = (x1 > x0) ? (x1 - x0) : (x0 - x1);
	assign dy = (y1 > y0) ? (y1 - y0) : (y0 - y1);

	// diagonal counts as shallow
	assign steep = (dy > dx);
	assign swap  = steep ? (y0 > y1) : (x0 > x1);

	always_comb begin
		if (steep) begin
			dmaj = dy;
			dmin = dx;
			maj0 = swap ? y1 : y0;
			maj1 = swap ? y0 : y1;
			min0 = swap ? x1 : x0;
			min1 = swap ? x0 : x1;
		end else begin
			dmaj = dx;
			dmin = dy;
			maj0 = swap ? x1 : x0;
			maj1 = swap ? x0 : x1;
			min0 = swap ? y1 : y0;
			min1 = swap ? y0 : y1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			major_q     <= maj0;
			minor_q     <= min0;
			major_end_q <= maj1;
			steep_q     <= steep;
			minor_up_q  <= (min0 < min1);
			err_q       <= $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
			inc_a_q     <= $signed({2'b00, dmin, 1'b0});
			inc_b_q     <= $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
		end else if (cmd.step) begin
			major_q <= major_q + coord_t'(1);
			if (err_q < 0) begin
				err_q <= err_q + inc_a_q;
			end else begin
				minor_q <= minor_up_q ? (minor_q + coord_t'(1)) : (minor_q - coord_t'(1));
				err_q   <= err_q + inc_b_q;
			end
		end
	end

	assign status.last = (major_q == major_end_q);
	assign last_pixel  = status.last;
	assign pixel_x     = steep_q ? minor_q : major_q;
	assign pixel_y     = steep_q ? major_q : minor_q;

endmodule

// ===== sv/line_rasterizer.sv =====
// The first pixel is offered in the cycle after the segment transaction.
// Throughput: one pixel per cycle while out_stall is low; a segment of
// max(|dx|,|dy|)+1 pixels is walked by the single Bresenham step unit,
// and no new segment is taken until its last pixel is transferred.
// Reset (arst_n low, asynchronous) returns the controller to idle; no
// pixel is pending afterward.
module line_rasterizer
	import lr_pkg::*;
#(
	parameter int TILE_SIZE = TILE_SIZE_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  coord_t x_begin,
	input  coord_t y_begin,
	input  coord_t x_finish,
	input  coord_t y_finish,
	output logic   out_valid,
	input  logic   out_stall,
	output coord_t pixel_x,
	output coord_t pixel_y,
	output logic   last_pixel
);

	lr_cmd_t    cmd;
	lr_status_t status;

	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	lr_datapath #(
		.TILE_SIZE (TILE_SIZE)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.x_begin    (x_begin),
		.y_begin    (y_begin),
		.x_finish   (x_finish),
		.y_finish   (y_finish),
		.status     (status),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel)
	);

	// the walk axis advances by exactly one after each non-final pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_pixel)
		|=> (out_valid && ((pixel_x == $past(pixel_x) + 6'd1) ||
		                   (pixel_y == $past(pixel_y) + 6'd1))))
		else $error("walk axis did not advance by one");

	// the final pixel transaction ends the segment
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_pixel) |=> !out_valid)
		else $error("pixel offered after last pixel");

	// a new segment is never taken while pixels are pending
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("segment accepted during emission");

	// the other coordinate moves by at most one per step
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_pixel)
		|=> ((pixel_x == $past(pixel_x)) || (pixel_x == $past(pixel_x) + 6'd1) ||
		     (pixel_x == $past(pixel_x) - 6'd1)) &&
		    ((pixel_y == $past(pixel_y)) || (pixel_y == $past(pixel_y) + 6'd1) ||
		     (pixel_y == $past(pixel_y) - 6'd1)))
		else $error("pixel step larger than one");

endmodule
